// ----- hw/rtl/egcd_pkg.sv -----
package egcd_pkg;

    localparam int OPERAND_BITS = 32;
    localparam int COEF_BITS    = OPERAND_BITS + 1;
    localparam int CNT_BITS     = $clog2(OPERAND_BITS);

    typedef logic [OPERAND_BITS-1:0] opnd_t;
    typedef logic [COEF_BITS-1:0]    coef_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- hw/rtl/egcd_div.sv -----
// Restoring divider, one quotient bit per cycle. The quotient bits also
// drive a Horner accumulation of q*cx and q*cy, so the products are ready
// together with the remainder.
module egcd_div
    import egcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  opnd_t       num,
    input  opnd_t       den,
    input  coef_t       cx,
    input  coef_t       cy,
    output opnd_t       rem,
    output coef_t       prod_x,
    output coef_t       prod_y,
    output div_status_t status
);

    localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(OPERAND_BITS - 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    opnd_t                   rem_reg;
    opnd_t                   quo_reg;
    opnd_t                   den_reg;
    coef_t                   cx_reg;
    coef_t                   cy_reg;
    coef_t                   acc_x_reg;
    coef_t                   acc_y_reg;

    logic [OPERAND_BITS:0]   shifted;
    logic [OPERAND_BITS+1:0] diff;
    logic                    qbit;
    opnd_t                   rem_next;
    coef_t                   acc_x_next;
    coef_t                   acc_y_next;

    always_comb
    begin
        shifted    = {rem_reg, quo_reg[OPERAND_BITS-1]};
        diff       = {1'b0, shifted} - {2'b00, den_reg};
        qbit       = ~diff[OPERAND_BITS+1];
        rem_next   = qbit ? diff[OPERAND_BITS-1:0] : shifted[OPERAND_BITS-1:0];
        acc_x_next = {acc_x_reg[COEF_BITS-2:0], 1'b0} + (qbit ? cx_reg : '0);
        acc_y_next = {acc_y_reg[COEF_BITS-2:0], 1'b0} + (qbit ? cy_reg : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_BITS'(1);
                if (cnt_reg == LAST_BIT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            quo_reg   <= num;
            den_reg   <= den;
            cx_reg    <= cx;
            cy_reg    <= cy;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            quo_reg   <= {quo_reg[OPERAND_BITS-2:0], qbit};
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
        end
    end

    assign rem         = rem_reg;
    assign prod_x      = acc_x_reg;
    assign prod_y      = acc_y_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- hw/rtl/extended_gcd_unit.sv -----
// Extended GCD unit: returns gcd(a,b) and Bezout coefficients x, y with
// x*a + y*b = gcd (x is the inverse of a mod b when the gcd is 1).
// Input channel: in_valid / in_stall with operand_a, operand_b. A request is
// taken when in_valid is high and in_stall low; in_stall is high while an
// item is being worked on.
// Output channel: out_valid / out_stall with divisor, coef_a, coef_b. The
// result sits in an output register until taken, and the next request is
// accepted meanwhile; a finished item waits in its row registers while the
// receiver stalls.
// Timing: each Euclid step is one division in the shared bit-serial divider
// (setup, one quotient bit per cycle, update); 32-bit operands need at most
// about 46 steps. A zero operand_b takes no step: divisor = operand_a,
// coef_a = 1, coef_b = 0.
// Reset (rst_n, asynchronous) drops any item in progress and the held
// result; the block comes out of reset ready for a request.
module extended_gcd_unit
    import egcd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [OPERAND_BITS-1:0]     operand_a,
    input  logic [OPERAND_BITS-1:0]     operand_b,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [OPERAND_BITS-1:0]     divisor,
    output logic signed [COEF_BITS-1:0] coef_a,
    output logic signed [COEF_BITS-1:0] coef_b
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t      state_reg;
    logic        out_valid_reg;
    opnd_t       num_reg;
    opnd_t       den_reg;
    coef_t       xn_reg;
    coef_t       yn_reg;
    coef_t       xd_reg;
    coef_t       yd_reg;
    opnd_t       divisor_reg;
    coef_t       coef_a_reg;
    coef_t       coef_b_reg;

    logic        accept;
    logic        start_div;
    logic        out_free;
    opnd_t       div_rem;
    coef_t       div_px;
    coef_t       div_py;
    div_status_t div_stat;
    coef_t       xn_next;
    coef_t       yn_next;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign start_div = (state_reg == ST_START);
    assign out_free  = !out_valid_reg || !out_stall;
    assign xn_next   = xn_reg - div_px;
    assign yn_next   = yn_reg - div_py;

    egcd_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_div),
        .num    (num_reg),
        .den    (den_reg),
        .cx     (xd_reg),
        .cy     (yd_reg),
        .rem    (div_rem),
        .prod_x (div_px),
        .prod_y (div_py),
        .status (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            divisor_reg   <= '0;
            coef_a_reg    <= '0;
            coef_b_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= (operand_b == '0) ? ST_FINISH : ST_START;
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= (div_rem == '0) ? ST_FINISH : ST_START;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        divisor_reg   <= den_reg;
                        coef_a_reg    <= xd_reg;
                        coef_b_reg    <= yd_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Row registers: num row is the dividend, den row the divisor; the final
    // answer is always the den row.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            num_reg <= operand_a;
            xn_reg  <= COEF_BITS'(1);
            yn_reg  <= '0;
            if (operand_b == '0)
            begin
                den_reg <= operand_a;
                xd_reg  <= COEF_BITS'(1);
                yd_reg  <= '0;
            end
            else
            begin
                den_reg <= operand_b;
                xd_reg  <= '0;
                yd_reg  <= COEF_BITS'(1);
            end
        end
        else if (state_reg == ST_DIVIDE && div_stat.done && div_rem != '0)
        begin
            num_reg <= den_reg;
            xn_reg  <= xd_reg;
            yn_reg  <= yd_reg;
            den_reg <= div_rem;
            xd_reg  <= xn_next;
            yd_reg  <= yn_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign divisor   = divisor_reg;
    assign coef_a    = signed'(coef_a_reg);
    assign coef_b    = signed'(coef_b_reg);

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        start_div |-> den_reg != '0)
        else $error("division started with zero divisor");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside divide state");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_div |=> div_stat.busy)
        else $error("divider not busy after start");

    a_zero_b_skip: assert property (@(posedge clk) disable iff (!rst_n)
        accept && operand_b == '0 |=> state_reg == ST_FINISH)
        else $error("zero second operand did not go straight to finish");

endmodule
